FILE: rtl/tmr_pkg.sv
package tmr_pkg;

    // vertex and edge coordinate width, signed
    localparam int VW = 14;
    // width of the edge dot products (e1.e1, e1.e2, e2.e2)
    localparam int DW = 2 * VW + 1;
    // register stages from request to result
    localparam int NUM_STAGES = 6;

    // configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 13;

    localparam logic [CFG_AW-1:0] REG_LENS_WIDTH    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_LENS_HEIGHT   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_OUTLINE_WIDTH = 3'd2;
    localparam logic [CFG_AW-1:0] REG_APEX_SIDE     = 3'd3;
    localparam logic [CFG_AW-1:0] REG_SCREEN_WIDTH  = 3'd4;

    // apex side codes
    localparam logic [1:0] SIDE_LEFT   = 2'd0;
    localparam logic [1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [1:0] SIDE_BOTTOM = 2'd2;
    localparam logic [1:0] SIDE_TOP    = 2'd3;

    typedef struct packed {
        logic [11:0] lens_width;
        logic [11:0] lens_height;
        logic [7:0]  outline_width;
        logic [1:0]  apex_side;
        logic [12:0] screen_width;
    } cfg_t;

    // buffer addresses carried alongside the inside test
    typedef struct packed {
        logic [23:0] lens_index;
        logic [25:0] screen_offset;
    } addr_t;

    // edge vectors e1 = B-A and e2 = C-A, each member a signed value
    typedef struct packed {
        logic [VW-1:0] e1x;
        logic [VW-1:0] e1y;
        logic [VW-1:0] e2x;
        logic [VW-1:0] e2y;
    } edge_t;

    // width of the pixel vector p = P-A for a given coordinate width
    function automatic int q_width(input int coord_bits);
        q_width = ((coord_bits > 13) ? coord_bits : 13) + 2;
    endfunction

endpackage

FILE: rtl/tmr_setup.sv
module tmr_setup
    import tmr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                                 clk,
    input  logic                                 en,
    input  cfg_t                                 cfg,
    input  logic [COORD_BITS-1:0]                pix_x,
    input  logic [COORD_BITS-1:0]                pix_y,
    output edge_t                                edges,
    output logic signed [q_width(COORD_BITS)-1:0] q_x,
    output logic signed [q_width(COORD_BITS)-1:0] q_y,
    output addr_t                                addr
);

    localparam int QW = q_width(COORD_BITS);

    logic signed [VW-1:0] w_s, h_s, o_s, hx, hy, half_w, half_h;
    logic signed [VW-1:0] ax, ay, bx, by, cx, cy;
    edge_t                edges_next, edges_reg;
    logic signed [QW-1:0] qx_next, qy_next, qx_reg, qy_reg;
    logic [23:0]          lin_idx, scr_idx;
    addr_t                addr_next, addr_reg;

    // inset box corners and side midpoints
    always_comb
    begin
        w_s    = $signed({2'b00, cfg.lens_width});
        h_s    = $signed({2'b00, cfg.lens_height});
        o_s    = $signed({6'b000000, cfg.outline_width});
        hx     = w_s - 14'sd1 - o_s;
        hy     = h_s - 14'sd1 - o_s;
        half_w = $signed({3'b000, cfg.lens_width[11:1]});
        half_h = $signed({3'b000, cfg.lens_height[11:1]});
    end

    // triangle vertices for the chosen apex side
    always_comb
    begin
        case (cfg.apex_side)
            SIDE_LEFT:
            begin
                ax = o_s;    ay = half_h; bx = hx;  by = o_s; cx = hx;  cy = hy;
            end
            SIDE_RIGHT:
            begin
                ax = hx;     ay = half_h; bx = o_s; by = o_s; cx = o_s; cy = hy;
            end
            SIDE_BOTTOM:
            begin
                ax = half_w; ay = hy;     bx = o_s; by = o_s; cx = hx;  cy = o_s;
            end
            default:
            begin
                ax = half_w; ay = o_s;    bx = hx;  by = hy;  cx = o_s; cy = hy;
            end
        endcase
    end

    // edge vectors, pixel vector and buffer addresses
    always_comb
    begin
        edges_next.e1x = bx - ax;
        edges_next.e1y = by - ay;
        edges_next.e2x = cx - ax;
        edges_next.e2y = cy - ay;
        qx_next = $signed({{(QW-COORD_BITS){1'b0}}, pix_x}) - QW'(ax);
        qy_next = $signed({{(QW-COORD_BITS){1'b0}}, pix_y}) - QW'(ay);
        lin_idx = 24'(pix_y) * 24'(cfg.lens_width) + 24'(pix_x);
        scr_idx = 24'(pix_y) * 24'(cfg.screen_width) + 24'(pix_x);
        addr_next.lens_index    = lin_idx;
        addr_next.screen_offset = {scr_idx, 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            edges_reg <= edges_next;
            qx_reg    <= qx_next;
            qy_reg    <= qy_next;
            addr_reg  <= addr_next;
        end
    end

    assign edges = edges_reg;
    assign q_x   = qx_reg;
    assign q_y   = qy_reg;
    assign addr  = addr_reg;

endmodule

FILE: rtl/tmr_dots.sv
module tmr_dots
    import tmr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                                             clk,
    input  logic [1:0]                                       en,
    input  edge_t                                            edges,
    input  logic signed [q_width(COORD_BITS)-1:0]            q_x,
    input  logic signed [q_width(COORD_BITS)-1:0]            q_y,
    input  addr_t                                            addr_in,
    output logic signed [DW-1:0]                             d11,
    output logic signed [DW-1:0]                             d12,
    output logic signed [DW-1:0]                             d22,
    output logic signed [VW+q_width(COORD_BITS):0]           d1p,
    output logic signed [VW+q_width(COORD_BITS):0]           d2p,
    output addr_t                                            addr_out
);

    localparam int QW = q_width(COORD_BITS);
    localparam int EE = 2 * VW;
    localparam int EQ = VW + QW;
    localparam int PW = EQ + 1;

    logic signed [VW-1:0] e1x, e1y, e2x, e2y;

    logic signed [EE-1:0] p11x_reg, p11y_reg, p12x_reg, p12y_reg, p22x_reg, p22y_reg;
    logic signed [EQ-1:0] p1px_reg, p1py_reg, p2px_reg, p2py_reg;
    addr_t                addr_a_reg;

    logic signed [DW-1:0] d11_reg, d12_reg, d22_reg;
    logic signed [PW-1:0] d1p_reg, d2p_reg;
    addr_t                addr_b_reg;

    assign e1x = $signed(edges.e1x);
    assign e1y = $signed(edges.e1y);
    assign e2x = $signed(edges.e2x);
    assign e2y = $signed(edges.e2y);

    // component products
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p11x_reg   <= EE'(e1x) * EE'(e1x);
            p11y_reg   <= EE'(e1y) * EE'(e1y);
            p12x_reg   <= EE'(e1x) * EE'(e2x);
            p12y_reg   <= EE'(e1y) * EE'(e2y);
            p22x_reg   <= EE'(e2x) * EE'(e2x);
            p22y_reg   <= EE'(e2y) * EE'(e2y);
            p1px_reg   <= EQ'(e1x) * EQ'(q_x);
            p1py_reg   <= EQ'(e1y) * EQ'(q_y);
            p2px_reg   <= EQ'(e2x) * EQ'(q_x);
            p2py_reg   <= EQ'(e2y) * EQ'(q_y);
            addr_a_reg <= addr_in;
        end
    end

    // dot products
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            d11_reg    <= DW'(p11x_reg) + DW'(p11y_reg);
            d12_reg    <= DW'(p12x_reg) + DW'(p12y_reg);
            d22_reg    <= DW'(p22x_reg) + DW'(p22y_reg);
            d1p_reg    <= PW'(p1px_reg) + PW'(p1py_reg);
            d2p_reg    <= PW'(p2px_reg) + PW'(p2py_reg);
            addr_b_reg <= addr_a_reg;
        end
    end

    assign d11      = d11_reg;
    assign d12      = d12_reg;
    assign d22      = d22_reg;
    assign d1p      = d1p_reg;
    assign d2p      = d2p_reg;
    assign addr_out = addr_b_reg;

endmodule

FILE: rtl/tmr_solve.sv
module tmr_solve
    import tmr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                                   clk,
    input  logic [2:0]                             en,
    input  logic signed [DW-1:0]                   d11,
    input  logic signed [DW-1:0]                   d12,
    input  logic signed [DW-1:0]                   d22,
    input  logic signed [VW+q_width(COORD_BITS):0] d1p,
    input  logic signed [VW+q_width(COORD_BITS):0] d2p,
    input  addr_t                                  addr_in,
    output logic                                   hit,
    output addr_t                                  addr_out
);

    localparam int PW  = VW + q_width(COORD_BITS) + 1;
    localparam int DPW = 2 * DW;
    localparam int MW  = DW + PW;
    localparam int DNW = DPW + 1;
    localparam int NW  = MW + 1;
    localparam int SW  = MW + 2;

    logic signed [DPW-1:0] m_dd_reg, m_cc_reg;
    logic signed [MW-1:0]  m_u1_reg, m_u2_reg, m_v1_reg, m_v2_reg;
    addr_t                 addr_a_reg;

    logic signed [DNW-1:0] den_reg;
    logic signed [NW-1:0]  nu_reg, nv_reg;
    addr_t                 addr_b_reg;

    logic signed [SW-1:0]  sum_uv, den_ext;
    logic                  inside_next, inside_reg;
    addr_t                 addr_c_reg;

    // cross products of the dot terms
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            m_dd_reg   <= DPW'(d11) * DPW'(d22);
            m_cc_reg   <= DPW'(d12) * DPW'(d12);
            m_u1_reg   <= MW'(d22) * MW'(d1p);
            m_u2_reg   <= MW'(d12) * MW'(d2p);
            m_v1_reg   <= MW'(d11) * MW'(d2p);
            m_v2_reg   <= MW'(d12) * MW'(d1p);
            addr_a_reg <= addr_in;
        end
    end

    // denominator and scaled barycentric numerators
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            den_reg    <= DNW'(m_dd_reg) - DNW'(m_cc_reg);
            nu_reg     <= NW'(m_u1_reg) - NW'(m_u2_reg);
            nv_reg     <= NW'(m_v1_reg) - NW'(m_v2_reg);
            addr_b_reg <= addr_a_reg;
        end
    end

    // strict inside test, degenerate triangle counts as outside
    always_comb
    begin
        sum_uv      = SW'(nu_reg) + SW'(nv_reg);
        den_ext     = SW'(den_reg);
        inside_next = !den_reg[DNW-1] && (den_reg != '0)
                      && !nu_reg[NW-1] && (nu_reg != '0)
                      && !nv_reg[NW-1] && (nv_reg != '0)
                      && (sum_uv < den_ext);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            inside_reg <= inside_next;
            addr_c_reg <= addr_b_reg;
        end
    end

    assign hit      = inside_reg;
    assign addr_out = addr_c_reg;

endmodule

FILE: rtl/triangle_mask_rasterizer.sv
// Point-in-triangle mask generator for a lens box. Each request carries one pixel
// (pix_x, pix_y); the result gives inside_res (pixel strictly inside the triangle
// whose apex sits mid-side on apex_side and whose base lies on the opposite edge,
// both inset by outline_width), the lens buffer index pix_y*lens_width+pix_x and
// the screen byte offset 4*(pix_y*screen_width+pix_x). The test is the exact
// integer barycentric test, so there is no rounding. The datapath is a six-stage
// pipeline (vertex setup, component products, dot products, cross products,
// numerators, compare); it takes one pixel per cycle while the result side is not
// stalled and returns each result in order. Every stage holds its own valid bit,
// so a stall on the result side only blocks once the pipeline has filled up. Write
// the configuration registers only while no request is in flight.
module triangle_mask_rasterizer
    import tmr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_AW-1:0]     cfg_index,
    input  logic [CFG_DW-1:0]     cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] pix_x,
    input  logic [COORD_BITS-1:0] pix_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  inside_res,
    output logic [23:0]           lens_index,
    output logic [25:0]           screen_offset
);

    localparam int QW = q_width(COORD_BITS);
    localparam int PW = VW + QW + 1;

    cfg_t                    cfg_reg, cfg_next;
    logic [NUM_STAGES-1:0]   valid_reg, valid_next, en;
    logic [NUM_STAGES:0]     rdy;

    edge_t                   edges;
    logic signed [QW-1:0]    q_x, q_y;
    addr_t                   addr_s1, addr_s3, addr_s6;
    logic signed [DW-1:0]    d11, d12, d22;
    logic signed [PW-1:0]    d1p, d2p;
    logic                    hit;

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LENS_WIDTH:    cfg_next.lens_width    = cfg_data[11:0];
                REG_LENS_HEIGHT:   cfg_next.lens_height   = cfg_data[11:0];
                REG_OUTLINE_WIDTH: cfg_next.outline_width = cfg_data[7:0];
                REG_APEX_SIDE:     cfg_next.apex_side     = cfg_data[1:0];
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data[12:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lens_width    <= 12'd256;
            cfg_reg.lens_height   <= 12'd256;
            cfg_reg.outline_width <= 8'd0;
            cfg_reg.apex_side     <= SIDE_LEFT;
            cfg_reg.screen_width  <= 13'd1024;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // per-stage flow control: a stage loads when it is empty or its successor moves
    always_comb
    begin
        rdy[NUM_STAGES] = out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        en = rdy[NUM_STAGES-1:0];
        valid_next = {valid_reg[NUM_STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= (valid_next & en) | (valid_reg & ~en);
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    // stage 1: vertices, edge vectors, addresses
    tmr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .clk   (clk),
        .en    (en[0]),
        .cfg   (cfg_reg),
        .pix_x (pix_x),
        .pix_y (pix_y),
        .edges (edges),
        .q_x   (q_x),
        .q_y   (q_y),
        .addr  (addr_s1)
    );

    // stages 2 and 3: dot products
    tmr_dots #(
        .COORD_BITS (COORD_BITS)
    ) u_dots (
        .clk      (clk),
        .en       (en[2:1]),
        .edges    (edges),
        .q_x      (q_x),
        .q_y      (q_y),
        .addr_in  (addr_s1),
        .d11      (d11),
        .d12      (d12),
        .d22      (d22),
        .d1p      (d1p),
        .d2p      (d2p),
        .addr_out (addr_s3)
    );

    // stages 4 to 6: numerators, denominator and compare
    tmr_solve #(
        .COORD_BITS (COORD_BITS)
    ) u_solve (
        .clk      (clk),
        .en       (en[5:3]),
        .d11      (d11),
        .d12      (d12),
        .d22      (d22),
        .d1p      (d1p),
        .d2p      (d2p),
        .addr_in  (addr_s3),
        .hit      (hit),
        .addr_out (addr_s6)
    );

    assign inside_res    = hit;
    assign lens_index    = addr_s6.lens_index;
    assign screen_offset = addr_s6.screen_offset;

endmodule

FILE: sim/tmr_checker.sv
`timescale 1ns / 100ps

module tmr_checker
    import tmr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_AW-1:0]     cfg_index,
    input  logic [CFG_DW-1:0]     cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [COORD_BITS-1:0] pix_x,
    input  logic [COORD_BITS-1:0] pix_y,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  inside_res,
    input  logic [23:0]           lens_index,
    input  logic [25:0]           screen_offset,
    output int                    mismatches,
    output int                    pending_results
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic        hit;
        logic [23:0] index;
        logic [25:0] offset;
    } pixel_result_t;

    cfg_t          shadow_cfg;
    pixel_result_t expected_pixels[$];
    pixel_result_t want;

    // exact integer barycentric test against the configured triangle
    function automatic logic inside_triangle(input cfg_t c, input longint px, input longint py);
        longint wl, hl, ol, hx, hy;
        longint ax, ay, bx, by, cx, cy;
        longint e1x, e1y, e2x, e2y, qx, qy;
        longint d11, d12, d22, d1p, d2p, den, nu, nv;
        wl = c.lens_width;
        hl = c.lens_height;
        ol = c.outline_width;
        hx = wl - 1 - ol;
        hy = hl - 1 - ol;
        case (c.apex_side)
            SIDE_LEFT:
            begin
                ax = ol;     ay = hl / 2; bx = hx; by = ol; cx = hx; cy = hy;
            end
            SIDE_RIGHT:
            begin
                ax = hx;     ay = hl / 2; bx = ol; by = ol; cx = ol; cy = hy;
            end
            SIDE_BOTTOM:
            begin
                ax = wl / 2; ay = hy;     bx = ol; by = ol; cx = hx; cy = ol;
            end
            default:
            begin
                ax = wl / 2; ay = ol;     bx = hx; by = hy; cx = ol; cy = hy;
            end
        endcase
        e1x = bx - ax; e1y = by - ay;
        e2x = cx - ax; e2y = cy - ay;
        qx  = px - ax; qy  = py - ay;
        d11 = e1x * e1x + e1y * e1y;
        d12 = e1x * e2x + e1y * e2y;
        d22 = e2x * e2x + e2y * e2y;
        d1p = e1x * qx + e1y * qy;
        d2p = e2x * qx + e2y * qy;
        den = d11 * d22 - d12 * d12;
        nu  = d22 * d1p - d12 * d2p;
        nv  = d11 * d2p - d12 * d1p;
        // flat triangle never contains anything
        return (den > 0) && (nu > 0) && (nv > 0) && (nu + nv < den);
    endfunction

    // full result for one pixel: mask bit plus both buffer addresses
    function automatic pixel_result_t predict_pixel(input cfg_t c,
                                                    input logic [COORD_BITS-1:0] x,
                                                    input logic [COORD_BITS-1:0] y);
        longint        xl, yl, wl, swl, lens_lin, scr_lin;
        pixel_result_t res;
        xl  = x;
        yl  = y;
        wl  = c.lens_width;
        swl = c.screen_width;
        lens_lin   = yl * wl + xl;
        scr_lin    = (yl * swl + xl) * 4;
        res.hit    = inside_triangle(c, xl, yl);
        res.index  = lens_lin[23:0];
        res.offset = scr_lin[25:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_cfg.lens_width    = 12'd256;
            shadow_cfg.lens_height   = 12'd256;
            shadow_cfg.outline_width = 8'd0;
            shadow_cfg.apex_side     = SIDE_LEFT;
            shadow_cfg.screen_width  = 13'd1024;
            expected_pixels.delete();
            mismatches      = 0;
            pending_results = 0;
        end
        else
        begin
            // accepted pixel request, predicted with the settings in force now
            if (in_valid && in_ready)
                expected_pixels.push_back(predict_pixel(shadow_cfg, pix_x, pix_y));

            // register write, unused indexes fall through
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LENS_WIDTH:    shadow_cfg.lens_width    = cfg_data[11:0];
                    REG_LENS_HEIGHT:   shadow_cfg.lens_height   = cfg_data[11:0];
                    REG_OUTLINE_WIDTH: shadow_cfg.outline_width = cfg_data[7:0];
                    REG_APEX_SIDE:     shadow_cfg.apex_side     = cfg_data[1:0];
                    REG_SCREEN_WIDTH:  shadow_cfg.screen_width  = cfg_data[12:0];
                    default: ;
                endcase
            end

            // returned result against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result with no request outstanding: %s=%0b %s=%0d %s=%0d",
                                 $realtime, "inside", inside_res, "index", lens_index,
                                 "offset", screen_offset);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (inside_res !== want.hit || lens_index !== want.index
                        || screen_offset !== want.offset)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("%0t: pixel result wrong: expected %s=%0b %s=%0d %s=%0d",
                                     $realtime, "inside", want.hit, "index", want.index,
                                     "offset", want.offset);
                            $display("%0t:                     got      %s=%0b %s=%0d %s=%0d",
                                     $realtime, "inside", inside_res, "index", lens_index,
                                     "offset", screen_offset);
                        end
                    end
                end
            end

            pending_results = expected_pixels.size();
        end
    end

endmodule

FILE: sim/triangle_mask_rasterizer_test.sv
`timescale 1ns / 100ps

module triangle_mask_rasterizer_test;

    import tmr_pkg::*;

    localparam int COORD_BITS    = 12;
    localparam int IDLE_PCT      = 13;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 70;
    localparam int QUIET_PHASE   = 2;
    localparam logic [CFG_AW-1:0] REG_UNUSED_FIRST = REG_SCREEN_WIDTH + CFG_AW'(1);

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_AW-1:0]     cfg_index;
    logic [CFG_DW-1:0]     cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;
    logic                  out_valid;
    logic                  out_ready;
    logic                  inside_res;
    logic [23:0]           lens_index;
    logic [25:0]           screen_offset;

    int   mismatches;
    int   pending_results;
    int   quiet_cycles;
    bit   idle_on;
    cfg_t lens_cfg;

    triangle_mask_rasterizer #(
        .COORD_BITS (COORD_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pix_x         (pix_x),
        .pix_y         (pix_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .inside_res    (inside_res),
        .lens_index    (lens_index),
        .screen_offset (screen_offset)
    );

    tmr_checker #(
        .COORD_BITS (COORD_BITS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pix_x           (pix_x),
        .pix_y           (pix_y),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .inside_res      (inside_res),
        .lens_index      (lens_index),
        .screen_offset   (screen_offset),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // result side back-pressure
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= !(idle_on && $urandom_range(99, 0) < IDLE_PCT);
        end
    end

    // abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // all five registers, then a stray write to an unused index
    task automatic set_config(input logic [11:0] w, input logic [11:0] h,
                              input logic [7:0] o, input logic [1:0] side,
                              input logic [12:0] sw);
        write_reg(REG_LENS_WIDTH, CFG_DW'(w));
        write_reg(REG_LENS_HEIGHT, CFG_DW'(h));
        write_reg(REG_OUTLINE_WIDTH, CFG_DW'(o));
        write_reg(REG_APEX_SIDE, CFG_DW'(side));
        write_reg(REG_SCREEN_WIDTH, sw);
        write_reg(CFG_AW'($urandom_range(2 ** CFG_AW - 1, REG_UNUSED_FIRST)),
                  CFG_DW'($urandom));
        lens_cfg.lens_width    = w;
        lens_cfg.lens_height   = h;
        lens_cfg.outline_width = o;
        lens_cfg.apex_side     = side;
        lens_cfg.screen_width  = sw;
    endtask

    // one pixel request, with a random gap ahead of it
    task automatic send_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
        @(negedge clk);
        while (idle_on && $urandom_range(99, 0) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pix_x    <= x;
        pix_y    <= y;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // hold requests until every result is back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
    endtask

    // box sizes biased toward tiny, medium and full
    function automatic logic [11:0] pick_size();
        case ($urandom_range(5, 0))
            0:       return 12'($urandom_range(4, 1));
            1:       return 12'($urandom_range(40, 5));
            2:       return 12'($urandom_range(300, 1));
            3:       return 12'd4095;
            default: return 12'($urandom_range(4095, 1));
        endcase
    endfunction

    initial
    begin
        logic [11:0] w;
        logic [11:0] h;
        logic [7:0]  o;
        logic [12:0] sw;
        logic [11:0] x;
        logic [11:0] y;
        int          inset_max;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_LENS_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        pix_x     = '0;
        pix_y     = '0;
        idle_on   = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: corners, apex vertex, base edge, just inside
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd128);
        send_pixel(12'd1, 12'd128);
        send_pixel(12'd254, 12'd128);
        send_pixel(12'd255, 12'd128);
        send_pixel(12'd128, 12'd64);

        // remaining apex sides on a small box
        for (int s = SIDE_RIGHT; s <= SIDE_TOP; s++)
        begin
            drain();
            set_config(12'd16, 12'd16, 8'd1, 2'(s), 13'd16);
            end_writes();
            send_pixel(12'd8, 12'd8);
            send_pixel(12'd2, 12'd13);
        end

        // one-pixel box, flat triangle
        drain();
        set_config(12'd1, 12'd1, 8'd0, SIDE_LEFT, 13'd1);
        end_writes();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd1);

        // inset far beyond the box
        drain();
        set_config(12'd5, 12'd5, 8'd255, SIDE_TOP, 13'd4096);
        end_writes();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);

        // zero lens width and zero screen width
        drain();
        set_config(12'd0, 12'd9, 8'd0, SIDE_RIGHT, 13'd0);
        end_writes();
        send_pixel(12'd7, 12'd9);

        // largest box, with over-wide register data that must be masked
        drain();
        set_config(12'd4095, 12'd4095, 8'd0, SIDE_LEFT, 13'd4096);
        write_reg(REG_LENS_WIDTH, 13'h1FFF);
        write_reg(REG_OUTLINE_WIDTH, 13'h1F00);
        write_reg(REG_APEX_SIDE, 13'h1FFC);
        end_writes();
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2047, 12'd2047);

        // random settings, one per phase, pixels mostly inside the box
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain();
            idle_on = (phase != QUIET_PHASE);
            w = pick_size();
            h = pick_size();
            inset_max = ((w < h) ? w : h) / 4;
            if (inset_max > 255)
                inset_max = 255;
            case ($urandom_range(3, 0))
                0:       o = 8'd0;
                1:       o = 8'd255;
                default: o = 8'($urandom_range(inset_max, 0));
            endcase
            case ($urandom_range(3, 0))
                0:       sw = 13'd4096;
                1:       sw = 13'd1;
                default: sw = 13'($urandom_range(4096, 1));
            endcase
            set_config(w, h, o, 2'(phase), sw);
            end_writes();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (lens_cfg.lens_width != 0 && $urandom_range(99, 0) < 85)
                    x = 12'($urandom_range(lens_cfg.lens_width - 1, 0));
                else
                    x = 12'($urandom);
                if (lens_cfg.lens_height != 0 && $urandom_range(99, 0) < 85)
                    y = 12'($urandom_range(lens_cfg.lens_height - 1, 0));
                else
                    y = 12'($urandom);
                send_pixel(x, y);
            end
        end

        drain();
        repeat (2 * NUM_STAGES) @(negedge clk);
        if (mismatches == 0 && pending_results == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tmr_pkg.sv
rtl/tmr_setup.sv
rtl/tmr_dots.sv
rtl/tmr_solve.sv
rtl/triangle_mask_rasterizer.sv
sim/tmr_checker.sv
sim/triangle_mask_rasterizer_test.sv
